[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset
`define RBE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while in reset
`define RBE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rbe_pkg.sv]
// Shared constants, types and command/status structs for the RNS base extension block
package rbe_pkg;

	localparam int NUM_BASE  = 4;
	localparam int NUM_FULL  = 8;
	localparam int FRAC_BITS = 48;
	localparam int NUM_CROSS = NUM_BASE * NUM_FULL;

	localparam int MOD_W   = 31;
	localparam int BW      = (NUM_BASE > 1) ? $clog2(NUM_BASE) : 1;
	localparam int JW      = $clog2(NUM_FULL);
	localparam int CW      = $clog2(NUM_CROSS);
	localparam int BIT_CW  = $clog2(MOD_W);
	localparam int FCW     = $clog2(FRAC_BITS);
	localparam int ALPHA_W = FRAC_BITS + $clog2(NUM_BASE + 1) + 3;
	localparam int R_W     = ALPHA_W - FRAC_BITS;

	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 40;
	localparam int CHAN_W    = 3;

	localparam logic KIND_TABLE   = 1'b0;
	localparam logic KIND_RESIDUE = 1'b1;

	localparam logic [1:0] TBL_MODULUS = 2'd0;
	localparam logic [1:0] TBL_INVERSE = 2'd1;
	localparam logic [1:0] TBL_CROSS   = 2'd2;
	localparam logic [1:0] TBL_PMOD    = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_T_MUL,
		ST_T_WAIT,
		ST_FRAC_GO,
		ST_FRAC_WAIT,
		ST_ROUND,
		ST_J_MUL,
		ST_J_WAIT,
		ST_P_MUL,
		ST_P_WAIT,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		OP_T,
		OP_CROSS,
		OP_PROD
	} op_sel_t;

	typedef struct packed {
		logic          mm_start;
		op_sel_t       sel;
		logic          t_store;
		logic          frac_start;
		logic          alpha_clr;
		logic          round;
		logic          sum_clr;
		logic          sum_add;
		logic          out_load;
		logic [BW-1:0] i;
		logic [JW-1:0] j;
	} cmd_t;

	typedef struct packed {
		logic mm_done;
		logic frac_done;
		logic out_free;
	} sts_t;

endpackage

[rtl/rbe_mulmod.sv]
// Bit-serial modular multiplier: reduces a mod p, then interleaved a*b mod p, negated on neg
module rbe_mulmod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rbe_pkg::MOD_W-1:0] a,
	input  logic [rbe_pkg::MOD_W-1:0] b,
	input  logic [rbe_pkg::MOD_W-1:0] p,
	input  logic                      neg,
	output logic                      done,
	output logic [rbe_pkg::MOD_W-1:0] result
);

	localparam int W = rbe_pkg::MOD_W;

	logic                        busy_q, phase_q, done_q, neg_q;
	logic [rbe_pkg::BIT_CW-1:0]  cnt_q;
	logic [W-1:0]                a_q, b_q, p_q, ar_q, acc_q, res_q;
	logic [W:0]                  sh0, red0;
	logic [W+1:0]                sh1, d1, d2;
	logic [W-1:0]                acc_nx;

	always_comb begin
		sh0  = {acc_q, a_q[cnt_q]};
		red0 = (sh0 >= {1'b0, p_q}) ? sh0 - {1'b0, p_q} : sh0;
		sh1  = {1'b0, acc_q, 1'b0} + (b_q[cnt_q] ? {2'b00, ar_q} : '0);
		d1   = (sh1 >= {2'b00, p_q}) ? sh1 - {2'b00, p_q} : sh1;
		d2   = (d1 >= {2'b00, p_q}) ? d1 - {2'b00, p_q} : d1;
		acc_nx = phase_q ? d2[W-1:0] : red0[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= rbe_pkg::BIT_CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					cnt_q <= rbe_pkg::BIT_CW'(W - 1);
					if (phase_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					phase_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			p_q   <= p;
			neg_q <= neg;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == '0 && !phase_q) begin
				// hand the reduced multiplicand over and restart the accumulator
				ar_q  <= acc_nx;
				acc_q <= '0;
			end else begin
				acc_q <= acc_nx;
			end
			if (cnt_q == '0 && phase_q) begin
				if (p_q == '0)
					res_q <= '0;
				else if (neg_q && acc_nx != '0)
					res_q <= p_q - acc_nx;
				else
					res_q <= acc_nx;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

[rtl/rbe_dp.sv]
// Datapath: tables, residue store, multiplier, fraction divider, accumulators, output register
module rbe_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_accept,
	input  logic                              kind,
	input  logic [1:0]                        tbl_sel,
	input  logic [4:0]                        index,
	input  logic [rbe_pkg::MOD_W-1:0]         table_value,
	input  logic signed [rbe_pkg::MOD_W-1:0]  residue,
	input  rbe_pkg::cmd_t                     cmd,
	output rbe_pkg::sts_t                     sts,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rbe_pkg::CHAN_W-1:0]        channel,
	output logic signed [rbe_pkg::MOD_W-1:0]  full_residue,
	output logic                              last_out
);

	localparam int W  = rbe_pkg::MOD_W;
	localparam int F  = rbe_pkg::FRAC_BITS;
	localparam int AW = rbe_pkg::ALPHA_W;
	localparam int RW = rbe_pkg::R_W;

	logic [W-1:0]        moduli_q [rbe_pkg::NUM_FULL];
	logic [W-1:0]        inv_q    [rbe_pkg::NUM_BASE];
	logic [W-1:0]        cross_q  [rbe_pkg::NUM_CROSS];
	logic [W-1:0]        pmod_q   [rbe_pkg::NUM_FULL];
	logic signed [W-1:0] ures_q   [rbe_pkg::NUM_BASE];
	logic signed [W-1:0] t_q      [rbe_pkg::NUM_BASE];

	logic signed [AW-1:0] alpha_q;
	logic signed [RW-1:0] r_q;
	logic [W-1:0]         sum_q;

	logic                 fbusy_q, fdone_q, fneg_q;
	logic [rbe_pkg::FCW-1:0] fcnt_q;
	logic [W-1:0]         frem_q, fp_q;
	logic [F-1:0]         fq_q;

	logic                 mv_q, last_q;
	logic [rbe_pkg::CHAN_W-1:0] chan_q;
	logic signed [W-1:0]  res_q;

	logic [W-1:0]         p_i, p_j, mm_a, mm_b, mm_p, mm_res;
	logic                 mm_neg, mm_done;
	logic [rbe_pkg::CW-1:0] ci;
	logic signed [W-1:0]  u_i, t_i;
	logic [W-1:0]         u_mag, t_mag;
	logic signed [RW-1:0] r_neg;
	logic [W:0]           frem2, fstep, sum2;
	logic [F:0]           fterm;
	logic [AW-1:0]        a_mag, a_rnd;
	logic [RW-1:0]        r_mag;
	logic signed [W:0]    v_raw, v_mod, t_cen, v_cen;

	always_comb begin
		p_i   = (int'(cmd.i) < rbe_pkg::NUM_FULL) ? moduli_q[rbe_pkg::JW'(cmd.i)] : '0;
		p_j   = moduli_q[cmd.j];
		ci    = rbe_pkg::CW'(int'(cmd.i) * rbe_pkg::NUM_FULL + int'(cmd.j));
		u_i   = ures_q[cmd.i];
		t_i   = t_q[cmd.i];
		u_mag = u_i[W-1] ? W'(-u_i) : W'(u_i);
		t_mag = t_i[W-1] ? W'(-t_i) : W'(t_i);
		r_neg = -r_q;
		case (cmd.sel)
			rbe_pkg::OP_CROSS: begin
				mm_a = t_mag; mm_b = cross_q[ci]; mm_p = p_j; mm_neg = t_i[W-1];
			end
			rbe_pkg::OP_PROD: begin
				mm_a = W'(r_q[RW-1] ? r_neg : r_q);
				mm_b = pmod_q[cmd.j]; mm_p = p_j; mm_neg = r_q[RW-1];
			end
			default: begin
				mm_a = u_mag; mm_b = inv_q[cmd.i]; mm_p = p_i; mm_neg = u_i[W-1];
			end
		endcase
		// centring of the base term modulo p_i
		t_cen = (mm_res > (p_i >> 1)) ? $signed({1'b0, mm_res}) - $signed({1'b0, p_i})
			: $signed({1'b0, mm_res});
		frem2 = {frem_q, 1'b0};
		fstep = (frem2 >= {1'b0, fp_q}) ? frem2 - {1'b0, fp_q} : frem2;
		fterm = {1'b0, fq_q} + ((frem2 >= {1'b0, fp_q}) ? (F + 1)'(1) : '0);
		a_mag = alpha_q[AW-1] ? AW'(-alpha_q) : AW'(alpha_q);
		a_rnd = a_mag + (AW'(1) << (F - 1));
		r_mag = a_rnd[AW-1:F];
		sum2  = {1'b0, sum_q} + {1'b0, mm_res};
		v_raw = $signed({1'b0, sum_q}) - $signed({1'b0, mm_res});
		v_mod = v_raw[W] ? v_raw + $signed({1'b0, p_j}) : v_raw;
		v_cen = (v_mod > $signed({2'b00, p_j[W-1:1]})) ? v_mod - $signed({1'b0, p_j}) : v_mod;
	end

	rbe_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.p      (mm_p),
		.neg    (mm_neg),
		.done   (mm_done),
		.result (mm_res)
	);

	// table, residue and base-term writes
	always_ff @(posedge clk) begin
		if (in_accept) begin
			if (kind == rbe_pkg::KIND_TABLE) begin
				case (tbl_sel)
					rbe_pkg::TBL_MODULUS:
						if (int'(index) < rbe_pkg::NUM_FULL)
							moduli_q[rbe_pkg::JW'(index)] <= table_value;
					rbe_pkg::TBL_INVERSE:
						if (int'(index) < rbe_pkg::NUM_BASE)
							inv_q[rbe_pkg::BW'(index)] <= table_value;
					rbe_pkg::TBL_CROSS:
						if (int'(index) < rbe_pkg::NUM_CROSS)
							cross_q[rbe_pkg::CW'(index)] <= table_value;
					default:
						if (int'(index) < rbe_pkg::NUM_FULL)
							pmod_q[rbe_pkg::JW'(index)] <= table_value;
				endcase
			end else if (int'(index) < rbe_pkg::NUM_BASE) begin
				ures_q[rbe_pkg::BW'(index)] <= residue;
			end
		end
		if (cmd.t_store)
			t_q[cmd.i] <= t_cen[W-1:0];
	end

	// fraction divider: |t_i| * 2^F / p_i, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fbusy_q <= 1'b0;
			fdone_q <= 1'b0;
			fcnt_q  <= '0;
		end else begin
			fdone_q <= 1'b0;
			if (cmd.frac_start) begin
				fbusy_q <= 1'b1;
				fcnt_q  <= rbe_pkg::FCW'(F - 1);
			end else if (fbusy_q) begin
				if (fcnt_q == '0) begin
					fbusy_q <= 1'b0;
					fdone_q <= 1'b1;
				end else begin
					fcnt_q <= fcnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.frac_start) begin
			frem_q <= t_mag;
			fp_q   <= p_i;
			fneg_q <= t_i[W-1];
			fq_q   <= '0;
		end else if (fbusy_q) begin
			frem_q <= fstep[W-1:0];
			fq_q   <= {fq_q[F-2:0], frem2 >= {1'b0, fp_q}};
		end
		if (cmd.alpha_clr)
			alpha_q <= '0;
		else if (fdone_q && fp_q != '0)
			alpha_q <= fneg_q ? alpha_q - $signed(AW'(fterm)) : alpha_q + $signed(AW'(fterm));
		if (cmd.round)
			r_q <= alpha_q[AW-1] ? -$signed(r_mag) : $signed(r_mag);
		if (cmd.sum_clr)
			sum_q <= '0;
		else if (cmd.sum_add)
			sum_q <= (sum2 >= {1'b0, p_j}) ? W'(sum2 - {1'b0, p_j}) : sum2[W-1:0];
		if (cmd.out_load) begin
			chan_q <= rbe_pkg::CHAN_W'(cmd.j);
			res_q  <= v_cen[W-1:0];
			last_q <= (int'(cmd.j) == rbe_pkg::NUM_FULL - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else if (cmd.out_load) begin
			mv_q <= 1'b1;
		end else if (m_tready) begin
			mv_q <= 1'b0;
		end
	end

	assign sts.mm_done   = mm_done;
	assign sts.frac_done = fdone_q;
	assign sts.out_free  = !mv_q || m_tready;

	assign m_tvalid     = mv_q;
	assign channel      = chan_q;
	assign full_residue = res_q;
	assign last_out     = last_q;

endmodule

[rtl/rbe_ctrl.sv]
// Controller: sequences the base terms, the rounding step and the per-channel sums
module rbe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          conv_req,
	output logic          in_ready,
	input  rbe_pkg::sts_t sts,
	output rbe_pkg::cmd_t cmd
);

	rbe_pkg::state_t state_q, state_nx;
	logic [rbe_pkg::BW-1:0] i_q;
	logic [rbe_pkg::JW-1:0] j_q;
	logic i_last, j_last, start;

	assign i_last = (int'(i_q) == rbe_pkg::NUM_BASE - 1);
	assign j_last = (int'(j_q) == rbe_pkg::NUM_FULL - 1);
	assign start  = (state_q == rbe_pkg::ST_IDLE) && in_valid && conv_req;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			rbe_pkg::ST_IDLE:      if (start) state_nx = rbe_pkg::ST_T_MUL;
			rbe_pkg::ST_T_MUL:     state_nx = rbe_pkg::ST_T_WAIT;
			rbe_pkg::ST_T_WAIT:    if (sts.mm_done) state_nx = rbe_pkg::ST_FRAC_GO;
			rbe_pkg::ST_FRAC_GO:   state_nx = rbe_pkg::ST_FRAC_WAIT;
			rbe_pkg::ST_FRAC_WAIT: if (sts.frac_done)
				state_nx = i_last ? rbe_pkg::ST_ROUND : rbe_pkg::ST_T_MUL;
			rbe_pkg::ST_ROUND:     state_nx = rbe_pkg::ST_J_MUL;
			rbe_pkg::ST_J_MUL:     state_nx = rbe_pkg::ST_J_WAIT;
			rbe_pkg::ST_J_WAIT:    if (sts.mm_done)
				state_nx = i_last ? rbe_pkg::ST_P_MUL : rbe_pkg::ST_J_MUL;
			rbe_pkg::ST_P_MUL:     state_nx = rbe_pkg::ST_P_WAIT;
			rbe_pkg::ST_P_WAIT:    if (sts.mm_done) state_nx = rbe_pkg::ST_EMIT;
			rbe_pkg::ST_EMIT:      if (sts.out_free)
				state_nx = j_last ? rbe_pkg::ST_IDLE : rbe_pkg::ST_J_MUL;
			default:               state_nx = rbe_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.sel      = rbe_pkg::OP_T;
		cmd.i        = i_q;
		cmd.j        = j_q;
		in_ready     = 1'b0;
		unique case (state_q)
			rbe_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.alpha_clr = start;
			end
			rbe_pkg::ST_T_MUL:    cmd.mm_start = 1'b1;
			rbe_pkg::ST_T_WAIT:   cmd.t_store = sts.mm_done;
			rbe_pkg::ST_FRAC_GO:  cmd.frac_start = 1'b1;
			rbe_pkg::ST_ROUND: begin
				cmd.round   = 1'b1;
				cmd.sum_clr = 1'b1;
			end
			rbe_pkg::ST_J_MUL: begin
				cmd.mm_start = 1'b1;
				cmd.sel      = rbe_pkg::OP_CROSS;
			end
			rbe_pkg::ST_J_WAIT: begin
				cmd.sel     = rbe_pkg::OP_CROSS;
				cmd.sum_add = sts.mm_done;
			end
			rbe_pkg::ST_P_MUL: begin
				cmd.mm_start = 1'b1;
				cmd.sel      = rbe_pkg::OP_PROD;
			end
			rbe_pkg::ST_P_WAIT:   cmd.sel = rbe_pkg::OP_PROD;
			rbe_pkg::ST_EMIT: begin
				cmd.sel      = rbe_pkg::OP_PROD;
				cmd.out_load = sts.out_free;
				cmd.sum_clr  = sts.out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbe_pkg::ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q) inside
				rbe_pkg::ST_IDLE: if (start) i_q <= '0;
				rbe_pkg::ST_FRAC_WAIT, rbe_pkg::ST_J_WAIT: begin
					if ((state_q == rbe_pkg::ST_FRAC_WAIT ? sts.frac_done : sts.mm_done)
						&& !i_last)
						i_q <= i_q + 1'b1;
				end
				rbe_pkg::ST_ROUND: begin
					i_q <= '0;
					j_q <= '0;
				end
				rbe_pkg::ST_EMIT: if (sts.out_free) begin
					i_q <= '0;
					if (!j_last) j_q <= j_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

[rtl/rns_base_extension.sv]
// The time from the last residue to the last result is set by the shared bit-serial multiplier and
// the bit-serial fraction divider; table and residue requests are accepted only while idle.
// One conversion at a time; the final result may wait in the output register while new requests enter.
// Asynchronous active-low reset clears control state; tables hold no reset value until written.
module rns_base_extension (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rbe_pkg::S_TDATA_W-1:0]     s_tdata,  // index, table_value, residue
	input  logic [rbe_pkg::S_TUSER_W-1:0]     s_tuser,  // kind, table_sel
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rbe_pkg::M_TDATA_W-1:0]     m_tdata,  // channel, full_residue
	output logic                              m_tlast
);

	rbe_pkg::cmd_t cmd;
	rbe_pkg::sts_t sts;
	logic [rbe_pkg::CHAN_W-1:0]       channel;
	logic signed [rbe_pkg::MOD_W-1:0] full_residue;
	logic in_accept, conv_req;

	assign in_accept = s_tvalid && s_tready;
	assign conv_req  = (s_tuser[0] == rbe_pkg::KIND_RESIDUE) && s_tlast;

	rbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.conv_req (conv_req),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rbe_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_accept    (in_accept),
		.kind         (s_tuser[0]),
		.tbl_sel      (s_tuser[2:1]),
		.index        (s_tdata[4:0]),
		.table_value  (s_tdata[35:5]),
		.residue      (s_tdata[66:36]),
		.cmd          (cmd),
		.sts          (sts),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.channel      (channel),
		.full_residue (full_residue),
		.last_out     (m_tlast)
	);

	assign m_tdata = {6'b0, full_residue, channel};

endmodule

[rtl/rbe_check.sv]
// Port-level checker for the RNS base extension block, bound to the top level
`include "assert_macros.svh"

module rbe_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [rbe_pkg::S_TUSER_W-1:0] s_tuser,
	input logic                          s_tlast,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [rbe_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tlast
);

	`RBE_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
	`RBE_ASSERT_NXT(a_conv_blocks, clk, arst_n, s_tvalid && s_tready && s_tuser[0] == rbe_pkg::KIND_RESIDUE && s_tlast, !s_tready, "request taken during conversion")
	`RBE_ASSERT_IMP(a_frame_busy, clk, arst_n, m_tvalid && !m_tlast, !s_tready, "ready before all channels emitted")

endmodule

bind rns_base_extension rbe_check u_check (.*);
